// ----- rtl/ccr_pkg.sv -----
// Shared types and constants for the clipped circle rasterizer.
package ccr_pkg;

	// Item command codes
	typedef enum logic [1:0] {
		MODE_OUTLINE = 2'd0,
		MODE_FILLED  = 2'd1,
		MODE_ADVANCE = 2'd2,
		MODE_NONE    = 2'd3
	} mode_t;

	// Clipping rectangle, inclusive bounds
	typedef struct packed {
		logic signed [15:0] left;
		logic signed [15:0] top;
		logic signed [15:0] right;
		logic signed [15:0] bottom;
	} clip_t;

	// Register map
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = 2;

	localparam logic [REG_IDX_W-1:0] REG_CLIP_LEFT   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_CLIP_TOP    = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_CLIP_RIGHT  = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_CLIP_BOTTOM = 2'd3;

	localparam logic signed [15:0] CLIP_LEFT_RST   = 16'sd0;
	localparam logic signed [15:0] CLIP_TOP_RST    = 16'sd0;
	localparam logic signed [15:0] CLIP_RIGHT_RST  = 16'sd1023;
	localparam logic signed [15:0] CLIP_BOTTOM_RST = 16'sd1023;

	// Last item index of one step: four spans or eight points
	localparam logic [2:0] FILL_LAST = 3'd3;
	localparam logic [2:0] LINE_LAST = 3'd7;

endpackage

// ----- rtl/ccr_if.sv -----
// Valid/ready channel interfaces for command items and result items.
interface ccr_item_if;
	logic               valid;
	logic               ready;
	logic [1:0]         mode;
	logic signed [14:0] center_x;
	logic signed [14:0] center_y;
	logic signed [14:0] radius;

	modport source (output valid, mode, center_x, center_y, radius, input ready);
	modport sink (input valid, mode, center_x, center_y, radius, output ready);
endinterface

interface ccr_result_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] span_start_x;
	logic signed [15:0] span_end_x;
	logic signed [15:0] row_y;
	logic               drawn;
	logic               last_item;
	logic               idle;

	modport source (output valid, span_start_x, span_end_x, row_y, drawn, last_item, idle,
		input ready);
	modport sink (input valid, span_start_x, span_end_x, row_y, drawn, last_item, idle,
		output ready);
endinterface

// ----- rtl/clipped_circle_rasterizer.sv -----
// Top level: Bresenham circle stepper with rectangle clipping.
// An accepted advance item passes through the input register and then the result register.
// Throughput: one item per cycle while a held result does not stall an advance; start and ignored items give no result.
// The step state updates as each item leaves the input register, so items follow back to back.
// Reset clears the pipeline valids and circle state; clip bounds return to 0, 0, 1023, 1023.
module clipped_circle_rasterizer #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [ccr_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [ccr_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [ccr_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready,
	ccr_item_if.sink                        items,
	ccr_result_if.source                    results
);

	// Sum width: enough for centre plus offset, and for the wrapped coordinate
	localparam int XW = (COORD_WIDTH > 17) ? COORD_WIDTH : 17;

	ccr_pkg::clip_t clip;

	ccr_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.clip    (clip)
	);

	// Input stage
	logic               valid_s1;
	logic [1:0]         mode_s1;
	logic signed [14:0] cx_s1;
	logic signed [14:0] cy_s1;
	logic signed [14:0] radius_s1;

	// Circle state
	logic signed [15:0] cx_q;
	logic signed [15:0] cy_q;
	logic signed [15:0] step_x_q;
	logic signed [15:0] step_y_q;
	logic signed [19:0] dec_q;
	logic [2:0]         octant_q;
	logic               filled_q;
	logic               busy_q;

	// Result register
	logic               res_valid_q;
	logic signed [15:0] res_x0_q;
	logic signed [15:0] res_x1_q;
	logic signed [15:0] res_row_q;
	logic               res_drawn_q;
	logic               res_last_q;
	logic               res_idle_q;

	ccr_pkg::mode_t     mode_e;
	logic               is_start;
	logic               is_adv;
	logic               out_free;
	logic               go;

	logic [2:0]         idx;
	logic               diag;
	logic               step_end;
	logic signed [15:0] col_ofs;
	logic signed [15:0] row_ofs;
	logic               col_neg;
	logic               row_neg;

	logic signed [XW-1:0]          cxe, cye, cole, rowe;
	logic signed [XW-1:0]          col_a, col_b, row_s;
	logic signed [COORD_WIDTH-1:0] col_a_w, col_b_w, row_w;
	logic signed [XW-1:0]          x0, x1, row;
	logic signed [XW-1:0]          cl, ct, cr, cb;
	logic signed [XW-1:0]          x0c, x1c;
	logic                          row_in;
	logic                          drawn;

	logic signed [19:0] xe, ye;
	logic signed [19:0] dec_next;
	logic signed [15:0] y_next;
	logic signed [16:0] nx17, ny17;
	logic               circle_end;

	assign mode_e   = ccr_pkg::mode_t'(mode_s1);
	assign is_start = (mode_e == ccr_pkg::MODE_OUTLINE) || (mode_e == ccr_pkg::MODE_FILLED);
	assign is_adv   = (mode_e == ccr_pkg::MODE_ADVANCE);
	assign out_free = !res_valid_q || results.ready;
	assign go       = valid_s1 && (!is_adv || out_free);

	assign items.ready = !valid_s1 || go;

	// Load the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (items.ready) begin
			valid_s1 <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (items.ready && items.valid) begin
			mode_s1   <= items.mode;
			cx_s1     <= items.center_x;
			cy_s1     <= items.center_y;
			radius_s1 <= items.radius;
		end
	end

	// Pick offsets and signs for the current point or span
	always_comb begin
		idx  = (filled_q && octant_q[2]) ? ccr_pkg::FILL_LAST : octant_q;
		diag = (idx[1] == idx[0]);
		step_end = (idx == (filled_q ? ccr_pkg::FILL_LAST : ccr_pkg::LINE_LAST));
		col_ofs  = diag ? step_x_q : step_y_q;
		row_ofs  = diag ? step_y_q : step_x_q;
		if (filled_q) begin
			col_neg = 1'b1;
			row_neg = !idx[1];
		end else begin
			col_neg = (idx[2] != idx[1]);
			row_neg = idx[2];
		end
	end

	// Form coordinates, wrap them and clip
	always_comb begin
		cxe   = XW'(cx_q);
		cye   = XW'(cy_q);
		cole  = XW'(col_ofs);
		rowe  = XW'(row_ofs);
		col_a = col_neg ? (cxe - cole) : (cxe + cole);
		col_b = cxe + cole;
		row_s = row_neg ? (cye - rowe) : (cye + rowe);

		col_a_w = COORD_WIDTH'(col_a);
		col_b_w = COORD_WIDTH'(col_b);
		row_w   = COORD_WIDTH'(row_s);
		x0  = XW'(col_a_w);
		row = XW'(row_w);
		x1  = filled_q ? XW'(col_b_w) : x0;

		cl = XW'(clip.left);
		ct = XW'(clip.top);
		cr = XW'(clip.right);
		cb = XW'(clip.bottom);

		row_in = (row >= ct) && (row <= cb);
		if (filled_q) begin
			x0c   = (x0 < cl) ? cl : x0;
			x1c   = (x1 > cr) ? cr : x1;
			drawn = (x1c >= x0c) && row_in;
		end else begin
			x0c   = x0;
			x1c   = x0;
			drawn = (x0 >= cl) && (x0 <= cr) && row_in;
		end
	end

	// Bresenham decision update at the end of a step
	always_comb begin
		xe   = 20'(step_x_q);
		ye   = 20'(step_y_q);
		if (dec_q < 20'sd0) begin
			dec_next = dec_q + (xe <<< 2) + 20'sd6;
			y_next   = step_y_q;
		end else begin
			dec_next = dec_q + ((xe - ye) <<< 2) + 20'sd10;
			y_next   = step_y_q - 16'sd1;
		end
		nx17       = 17'(step_x_q) + 17'sd1;
		ny17       = 17'(y_next);
		circle_end = step_end && (nx17 > ny17);
	end

	// Advance the circle state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q     <= '0;
			cy_q     <= '0;
			step_x_q <= '0;
			step_y_q <= '0;
			dec_q    <= '0;
			octant_q <= '0;
			filled_q <= 1'b0;
			busy_q   <= 1'b0;
		end else if (go) begin
			if (is_start) begin
				cx_q     <= 16'(cx_s1);
				cy_q     <= 16'(cy_s1);
				step_x_q <= '0;
				step_y_q <= 16'(radius_s1);
				dec_q    <= 20'sd3 - (20'(radius_s1) <<< 1);
				octant_q <= '0;
				filled_q <= (mode_e == ccr_pkg::MODE_FILLED);
				busy_q   <= !radius_s1[14];
			end else if (is_adv && busy_q) begin
				if (step_end) begin
					dec_q    <= dec_next;
					step_x_q <= nx17[15:0];
					step_y_q <= y_next;
					octant_q <= '0;
					if (circle_end) begin
						busy_q <= 1'b0;
					end
				end else begin
					octant_q <= idx + 3'd1;
				end
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (go && is_adv) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && is_adv) begin
			if (busy_q) begin
				res_x0_q    <= x0c[15:0];
				res_x1_q    <= x1c[15:0];
				res_row_q   <= row[15:0];
				res_drawn_q <= drawn;
				res_last_q  <= circle_end;
				res_idle_q  <= 1'b0;
			end else begin
				res_x0_q    <= '0;
				res_x1_q    <= '0;
				res_row_q   <= '0;
				res_drawn_q <= 1'b0;
				res_last_q  <= 1'b0;
				res_idle_q  <= 1'b1;
			end
		end
	end

	assign results.valid        = res_valid_q;
	assign results.span_start_x = res_x0_q;
	assign results.span_end_x   = res_x1_q;
	assign results.row_y        = res_row_q;
	assign results.drawn        = res_drawn_q;
	assign results.last_item    = res_last_q;
	assign results.idle         = res_idle_q;

	// Step coordinates stay ordered while a circle runs
	a_step_order: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (step_x_q <= step_y_q))
		else $error("step_x passed step_y while busy");

	// No circle in progress means the point index is at rest
	a_idle_octant: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (octant_q == 3'd0))
		else $error("octant index nonzero with no circle active");

	// Filled circles use four spans per step
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		filled_q |-> !octant_q[2])
		else $error("filled mode index beyond four spans");

	// Final item of a circle ends the circle
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(go && is_adv && busy_q && circle_end) |=> !busy_q)
		else $error("busy stayed set after final item");

	// Stalled input stage only when an item is held
	a_ready_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!items.ready |-> (valid_s1 && is_adv && res_valid_q))
		else $error("input stalled without a blocked advance");

endmodule

// ----- rtl/ccr_apb_regs.sv -----
// APB register file holding the clipping rectangle.
module ccr_apb_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [ccr_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [ccr_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [ccr_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready,
	output ccr_pkg::clip_t                  clip
);

	ccr_pkg::clip_t              clip_q;
	logic [ccr_pkg::REG_IDX_W-1:0] reg_idx;
	logic                        wr_en;

	assign reg_idx = paddr[ccr_pkg::APB_ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign clip    = clip_q;

	// Write the addressed bound on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_q.left   <= ccr_pkg::CLIP_LEFT_RST;
			clip_q.top    <= ccr_pkg::CLIP_TOP_RST;
			clip_q.right  <= ccr_pkg::CLIP_RIGHT_RST;
			clip_q.bottom <= ccr_pkg::CLIP_BOTTOM_RST;
		end else if (wr_en) begin
			case (reg_idx)
				ccr_pkg::REG_CLIP_LEFT:   clip_q.left   <= pwdata[15:0];
				ccr_pkg::REG_CLIP_TOP:    clip_q.top    <= pwdata[15:0];
				ccr_pkg::REG_CLIP_RIGHT:  clip_q.right  <= pwdata[15:0];
				ccr_pkg::REG_CLIP_BOTTOM: clip_q.bottom <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Read back, sign-extended to the bus width
	always_comb begin
		case (reg_idx)
			ccr_pkg::REG_CLIP_LEFT:   prdata = ccr_pkg::APB_DATA_W'(clip_q.left);
			ccr_pkg::REG_CLIP_TOP:    prdata = ccr_pkg::APB_DATA_W'(clip_q.top);
			ccr_pkg::REG_CLIP_RIGHT:  prdata = ccr_pkg::APB_DATA_W'(clip_q.right);
			ccr_pkg::REG_CLIP_BOTTOM: prdata = ccr_pkg::APB_DATA_W'(clip_q.bottom);
			default:                  prdata = '0;
		endcase
	end

endmodule
